// ----- design/rgba_3x3_convolution_filter_macros.svh -----
// Assertion macros used by the checker file of the 3x3 convolution filter.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef RGBA_3X3_CONVOLUTION_FILTER_MACROS_SVH
`define RGBA_3X3_CONVOLUTION_FILTER_MACROS_SVH

// same-cycle implication
`define RCF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rcf_pkg.sv -----
// Package of the 3x3 convolution filter: beat types, register codes, constants.
// No dependencies; imported by the front end, back end, top level and checker.
`default_nettype none

package rcf_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_DW = 12;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [CFG_DW-1:0] RST_WIDTH  = 12'd640;
  localparam logic [CFG_DW-1:0] RST_HEIGHT = 12'd480;

  localparam int QDEPTH = 4;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // floor(v/9) and floor(v/3) by reciprocal, exact over the value ranges used
  localparam int RECIP_SHIFT = 16;
  localparam int DIV9_RECIP  = 7282;
  localparam int DIV3_RECIP  = 21846;

  typedef enum logic [1:0] {
    MODE_EDGE,
    MODE_SHARPEN,
    MODE_BLUR,
    MODE_GREY
  } mode_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       frame_last;
  } out_item_t;

  // blue in [7:0], green [15:8], red [23:16], alpha [31:24]
  typedef logic [31:0] pixel_t;

  typedef struct packed {
    logic top_out;
    logic bot_out;
    logic left_out;
    logic right_out;
    logic last;
  } border_t;

  typedef struct packed {
    logic [8:0][23:0] win;
    logic [7:0]       alpha;
    border_t          border;
    mode_t            mode;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage

`default_nettype wire

// ----- design/rcf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line stores of the convolution filter.
`default_nettype none

module rcf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/rcf_front.sv -----
// Front end: config registers, beat classification, frame counters, line stores, window.
// Depends on rcf_pkg and rcf_ram; emits one job per result into the queue.
`default_nettype none

module rcf_front import rcf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  input  wire logic [QCW-1:0]    q_count,
  output logic                   job_valid,
  output job_t                   job
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  mode_t             mode_r;
  logic [CFG_DW-1:0] width_r;
  logic [CFG_DW-1:0] height_r;
  logic [AW-1:0]     w_last;
  logic [RW-1:0]     h_last;

  logic [AW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic    accept, flushing, ignore, take, emit, restart;
  border_t brd;
  pixel_t  pix;

  logic    s1_valid_r, s1_emit_r;
  pixel_t  s1_pix_r;
  logic [AW-1:0] s1_addr_r;
  border_t s1_border_r;
  mode_t   s1_mode_r;

  logic        fwd_r;
  logic [63:0] fwd_data_r;
  logic [63:0] ram_rdata, rd_eff, wr_data;
  pixel_t      upper_old, middle_old;

  pixel_t win_r [9];
  pixel_t win_nxt [9];

  always_comb begin
    if (width_r == '0) begin
      w_last = '0;
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_last = AW'(MAX_WIDTH - 1);
    end else begin
      w_last = AW'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      h_last = '0;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(height_r - 1'b1);
    end
  end

  assign in_ready = ((QCW+1)'(q_count) + (QCW+1)'(s1_emit_r & s1_valid_r))
                    < (QCW+1)'(QDEPTH);
  assign accept   = in_valid & in_ready;
  assign flushing = in_row_r > h_last;
  assign ignore   = !flushing && in_data.cmd;
  assign take     = accept && !ignore;
  assign emit     = (in_row_r > RW'(1)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  assign restart  = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH) ||
                               (cfg_index == CFG_IMAGE_HEIGHT));
  assign pix      = flushing ? '0 : {in_data.in_alpha, in_data.in_red,
                                     in_data.in_green, in_data.in_blue};

  always_comb begin
    brd.top_out   = (out_row_r == '0);
    brd.bot_out   = (out_row_r == h_last);
    brd.left_out  = (out_col_r == '0);
    brd.right_out = (out_col_r == w_last);
    brd.last      = brd.bot_out && brd.right_out;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      if (in_col_r == w_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (out_col_r == w_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
        if (brd.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
  end

  rcf_ram #(
    .WIDTH(64),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_valid_r),
    .waddr(s1_addr_r),
    .wdata(wr_data),
    .re   (take),
    .raddr(in_col_r),
    .rdata(ram_rdata)
  );

  assign rd_eff     = fwd_r ? fwd_data_r : ram_rdata;
  assign upper_old  = rd_eff[63:32];
  assign middle_old = rd_eff[31:0];
  assign wr_data    = {middle_old, s1_pix_r};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]   = win_r[i*3+1];
      win_nxt[i*3+1] = win_r[i*3+2];
    end
    win_nxt[2] = upper_old;
    win_nxt[5] = middle_old;
    win_nxt[8] = s1_pix_r;
  end

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      job.win[n] = win_nxt[n][23:0];
    end
    job.alpha  = win_nxt[4][31:24];
    job.border = s1_border_r;
    job.mode   = s1_mode_r;
  end

  assign job_valid = s1_valid_r & s1_emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_EDGE;
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      fwd_r      <= 1'b0;
      for (int n = 0; n < 9; n++) begin
        win_r[n] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FILTER_MODE:  mode_r   <= mode_t'(cfg_wdata[1:0]);
          CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      s1_valid_r <= take;
      s1_emit_r  <= emit;
      fwd_r      <= take && s1_valid_r && (s1_addr_r == in_col_r);
      if (restart) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
      end
      priority if (restart || (s1_valid_r && s1_emit_r && s1_border_r.last)) begin
        for (int n = 0; n < 9; n++) begin
          win_r[n] <= '0;
        end
      end else if (s1_valid_r) begin
        for (int n = 0; n < 9; n++) begin
          win_r[n] <= win_nxt[n];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r    <= pix;
      s1_addr_r   <= in_col_r;
      s1_border_r <= brd;
      s1_mode_r   <= mode_r;
    end
    fwd_data_r <= wr_data;
  end

endmodule

`default_nettype wire

// ----- design/rcf_fifo.sv -----
// Short register queue between the front end and the arithmetic back end.
// No dependencies; the producer guarantees room through the count output.
`default_nettype none

module rcf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  output logic                            pop_valid,
  input  wire logic                       pop_ready,
  output logic      [WIDTH-1:0]           pop_data,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             pop;

  assign pop       = pop_valid & pop_ready;
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/rcf_back.sv -----
// Back end: border masking, 3x3 sums, mode select, clamp and the output register.
// Depends on rcf_pkg; pulls jobs from the queue and drives the result channel.
`default_nettype none

module rcf_back import rcf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_valid,
  output logic           job_ready,
  input  wire job_t      job,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic [10:0] s8   [3];
  logic [9:0]  x4   [3];
  logic [7:0]  v    [3][9];
  logic [9:0]  gsum;

  logic        a_valid_r;
  logic [10:0] a_s8_r [3];
  logic [9:0]  a_x4_r [3];
  logic [7:0]  a_c_r  [3];
  logic [9:0]  a_gsum_r;
  logic [7:0]  a_alpha_r;
  logic        a_last_r;
  mode_t       a_mode_r;

  logic signed [12:0] lin       [3];
  logic [11:0]        bsum      [3];
  logic [25:0]        blur_prod [3];
  logic [25:0]        grey_prod;
  logic [7:0]         res       [3];

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      a_load, b_load;

  assign b_load    = a_valid_r && (!out_valid_r || out_ready);
  assign job_ready = !a_valid_r || b_load;
  assign a_load    = job_valid && job_ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((i == 0 && job.border.top_out) || (i == 2 && job.border.bot_out) ||
              (j == 0 && job.border.left_out) || (j == 2 && job.border.right_out)) begin
            v[k][i*3+j] = '0;
          end else begin
            v[k][i*3+j] = job.win[i*3+j][8*k +: 8];
          end
        end
      end
      s8[k] = 11'(v[k][0]) + 11'(v[k][1]) + 11'(v[k][2]) + 11'(v[k][3]) +
              11'(v[k][5]) + 11'(v[k][6]) + 11'(v[k][7]) + 11'(v[k][8]);
      x4[k] = 10'(v[k][1]) + 10'(v[k][3]) + 10'(v[k][5]) + 10'(v[k][7]);
    end
    gsum = 10'(job.win[4][7:0]) + 10'(job.win[4][15:8]) + 10'(job.win[4][23:16]);
  end

  always_comb begin
    grey_prod = 26'(a_gsum_r) * 26'(DIV3_RECIP);
    for (int k = 0; k < 3; k++) begin
      bsum[k]      = 12'(a_s8_r[k]) + 12'(a_c_r[k]);
      blur_prod[k] = 26'(bsum[k]) * 26'(DIV9_RECIP);
      lin[k]       = '0;
      res[k]       = '0;
      unique case (a_mode_r)
        MODE_EDGE: begin
          lin[k] = $signed({2'b00, a_c_r[k], 3'b000}) - $signed({2'b00, a_s8_r[k]});
        end
        MODE_SHARPEN: begin
          lin[k] = $signed(13'({a_c_r[k], 2'b00}) + 13'(a_c_r[k])) -
                   $signed(13'(a_x4_r[k]));
        end
        MODE_BLUR: res[k] = blur_prod[k][RECIP_SHIFT +: 8];
        MODE_GREY: res[k] = grey_prod[RECIP_SHIFT +: 8];
        default:   res[k] = '0;
      endcase
      if (a_mode_r == MODE_EDGE || a_mode_r == MODE_SHARPEN) begin
        priority if (lin[k] < 0) begin
          res[k] = '0;
        end else if (lin[k] > 13'sd255) begin
          res[k] = 8'hFF;
        end else begin
          res[k] = lin[k][7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_ready) begin
        a_valid_r <= job_valid;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      for (int k = 0; k < 3; k++) begin
        a_s8_r[k] <= s8[k];
        a_x4_r[k] <= x4[k];
        a_c_r[k]  <= job.win[4][8*k +: 8];
      end
      a_gsum_r  <= gsum;
      a_alpha_r <= job.alpha;
      a_last_r  <= job.border.last;
      a_mode_r  <= job.mode;
    end
    if (b_load) begin
      out_data_r.out_blue   <= res[0];
      out_data_r.out_green  <= res[1];
      out_data_r.out_red    <= res[2];
      out_data_r.out_alpha  <= a_alpha_r;
      out_data_r.frame_last <= a_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- design/rgba_3x3_convolution_filter.sv -----
// Top level of the streaming 3x3 convolution filter; depends on rcf_pkg, rcf_front, rcf_fifo, rcf_back.
// Throughput: one beat per cycle in and out while the queue has room and out_ready is high.
// Pipeline: s1 register, queue, a-stage register, output register. A pixel's window is
// completed image_width+1 beats later in the stream; image_width+1 flush beats drain a frame.
// Reset: synchronous, active low; clears registers, counters, window, queue and pipeline
// valids. Line stores are not cleared and there is no clearing pass.
`default_nettype none

module rgba_3x3_convolution_filter import rcf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data
);

  logic           job_valid;
  job_t           front_job;
  logic           q_valid;
  logic           q_ready;
  job_t           q_job;
  logic [QCW-1:0] q_count;

  rcf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_count  (q_count),
    .job_valid(job_valid),
    .job      (front_job)
  );

  rcf_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_data(front_job),
    .pop_valid(q_valid),
    .pop_ready(q_ready),
    .pop_data (q_job),
    .count    (q_count)
  );

  rcf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(q_valid),
    .job_ready(q_ready),
    .job      (q_job),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- design/rcf_checker.sv -----
// Port-level checker for the 3x3 convolution filter, bound to the top level.
// Depends on rcf_pkg and rgba_3x3_convolution_filter_macros.svh.
`default_nettype none
`include "rgba_3x3_convolution_filter_macros.svh"

module rcf_checker import rcf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              cfg_we,
  input wire logic [CFG_IW-1:0] cfg_index,
  input wire logic [CFG_DW-1:0] cfg_wdata,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire out_item_t         out_data
);

  logic grey_r, grey_nxt;
  logic seen_in_r, seen_in_nxt;

  assign seen_in_nxt = seen_in_r | (in_valid & in_ready);
  assign grey_nxt    = (cfg_we && (cfg_index == CFG_FILTER_MODE)) ?
                       (cfg_wdata[1:0] == MODE_GREY) : grey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grey_r    <= 1'b0;
      seen_in_r <= 1'b0;
    end else begin
      grey_r    <= grey_nxt;
      seen_in_r <= seen_in_nxt;
    end
  end

  `RCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped")
  `RCF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data), "stalled result changed")
  `RCF_ASSERT_IMPLY(a_no_early_out, clk, rst_n, out_valid, seen_in_r, "result before any input beat")
  `RCF_ASSERT_IMPLY(a_grey_equal, clk, rst_n, out_valid && grey_r, (out_data.out_blue == out_data.out_green) && (out_data.out_green == out_data.out_red), "grey channels differ")

endmodule

bind rgba_3x3_convolution_filter rcf_checker u_rcf_checker (.*);

`default_nettype wire
